>>> design/ah_pkg.sv
// shared types and constants of the addressable min-heap
package ah_pkg;

    localparam int HDL_W        = 6;
    localparam int HANDLES      = 64;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int IO_KEY_W     = 32;
    localparam int CMD_W        = 2;
    localparam int STS_W        = 3;
    localparam int CNT_OUT_W    = 7;
    localparam int S_DATA_W     = 40;
    localparam int M_DATA_W     = 88;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_ERASE   = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_FULL        = 3'd2,
        ST_NOT_PRESENT = 3'd3,
        ST_IN_USE      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_REJECT,
        DP_PUSH,
        DP_CHANGE,
        DP_RD_ROOT,
        DP_RD_POS,
        DP_TAKE,
        DP_RD_LAST,
        DP_MV_LAST,
        DP_RD_PARENT,
        DP_UP_MOVE,
        DP_RD_LEFT,
        DP_RD_RIGHT,
        DP_DOWN_MOVE,
        DP_PLACE
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
        logic    result;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic live;
        logic empty;
        logic pos_zero;
        logic try_down;
        logic up_less;
        logic has_left;
        logic dn_less;
        logic at_last;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> design/ah_dp.sv
// heap datapath: slot memories, handle map, live bits, moving entry and result register
module ah_dp
    import ah_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [CMD_W-1:0]     i_in_cmd,
    input  logic [IO_KEY_W-1:0]  i_in_key,
    input  logic [HDL_W-1:0]     i_in_hdl,
    input  logic                 i_m_tready,
    output t_dp_sts              o_sts,
    output logic                 o_m_tvalid,
    output logic [M_DATA_W-1:0]  o_m_tdata,
    output logic [STS_W-1:0]     o_m_tuser
);

    localparam int PW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = PW + 1;

    logic signed [KEY_BITS-1:0] mem_key [CAPACITY];
    logic [HDL_W-1:0]           mem_hdl [CAPACITY];
    logic [PW-1:0]              mem_pos [HANDLES];

    t_cmd                       r_cmd;
    logic signed [KEY_BITS-1:0] r_key;
    logic [HDL_W-1:0]           r_hdl;
    logic [PW-1:0]              r_hpos;
    logic [HANDLES-1:0]         r_live;
    logic [CW-1:0]              r_count;
    logic [PW-1:0]              r_pos;
    logic signed [KEY_BITS-1:0] r_mv_key;
    logic [HDL_W-1:0]           r_mv_hdl;
    logic                       r_try_down;
    logic signed [KEY_BITS-1:0] r_lft_key;
    logic [HDL_W-1:0]           r_lft_hdl;
    logic signed [KEY_BITS-1:0] r_rd_key;
    logic [HDL_W-1:0]           r_rd_hdl;
    t_status                    r_status;
    logic signed [KEY_BITS-1:0] r_okey;
    logic [HDL_W-1:0]           r_ohdl;
    logic                       r_m_valid;
    logic [M_DATA_W-1:0]        r_m_data;
    logic [STS_W-1:0]           r_m_user;

    logic [PW-1:0]              rd_addr;
    logic                       wr_en;
    logic [PW-1:0]              wr_addr;
    logic signed [KEY_BITS-1:0] wr_key;
    logic [HDL_W-1:0]           wr_hdl;
    logic [PW-1:0]              parent;
    logic [CIW-1:0]             left_idx;
    logic [CIW-1:0]             right_idx;
    logic                       pick_right;
    logic signed [KEY_BITS-1:0] c_key;
    logic [HDL_W-1:0]           c_hdl;
    logic [PW-1:0]              c_idx;
    logic                       is_empty;
    logic signed [KEY_BITS-1:0] min_key;
    logic [HDL_W-1:0]           min_hdl;

    assign parent     = PW'((r_pos - 1'b1) >> 1);
    assign left_idx   = {r_pos, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    // right child wins only when strictly smaller than the left
    assign pick_right = (right_idx < CIW'(r_count)) && (r_rd_key < r_lft_key);
    assign c_key      = pick_right ? r_rd_key : r_lft_key;
    assign c_hdl      = pick_right ? r_rd_hdl : r_lft_hdl;
    assign c_idx      = pick_right ? PW'(right_idx) : PW'(left_idx);

    assign is_empty = (r_count == '0);
    assign min_key  = is_empty ? '0 : r_rd_key;
    assign min_hdl  = is_empty ? '0 : r_rd_hdl;

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.full     = (r_count >= CW'(CAPACITY));
        o_sts.live     = r_live[r_hdl];
        o_sts.empty    = is_empty;
        o_sts.pos_zero = (r_pos == '0);
        o_sts.try_down = r_try_down;
        o_sts.up_less  = (r_mv_key < r_rd_key);
        o_sts.has_left = (left_idx < CIW'(r_count));
        o_sts.dn_less  = (c_key < r_mv_key);
        o_sts.at_last  = (CW'(r_pos) == r_count);
        o_sts.out_busy = r_m_valid && !i_m_tready;
    end

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_key  = r_mv_key;
        wr_hdl  = r_mv_hdl;
        unique case (i_cmd.op)
            DP_RD_PARENT: rd_addr = parent;
            DP_RD_LEFT:   rd_addr = PW'(left_idx);
            DP_RD_RIGHT:  rd_addr = PW'(right_idx);
            DP_RD_POS:    rd_addr = r_hpos;
            DP_RD_LAST:   rd_addr = PW'(r_count);
            DP_UP_MOVE: begin
                wr_en  = 1'b1;
                wr_key = r_rd_key;
                wr_hdl = r_rd_hdl;
            end
            DP_DOWN_MOVE: begin
                wr_en  = 1'b1;
                wr_key = c_key;
                wr_hdl = c_hdl;
            end
            DP_PLACE:     wr_en = 1'b1;
            default:      rd_addr = '0;
        endcase
    end

    // slot memories and handle map
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_hdl[wr_addr] <= wr_hdl;
            mem_pos[wr_hdl]  <= wr_addr;
        end
        r_rd_key <= mem_key[rd_addr];
        r_rd_hdl <= mem_hdl[rd_addr];
        if (i_cmd.op == DP_LOAD) begin
            r_hpos <= mem_pos[i_in_hdl];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_PUSH) begin
                r_live[r_hdl] <= 1'b1;
                r_count       <= r_count + 1'b1;
            end
            if (i_cmd.op == DP_TAKE) begin
                r_live[r_rd_hdl] <= 1'b0;
                r_count          <= r_count - 1'b1;
            end
            if (i_cmd.result) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_cmd    <= t_cmd'(i_in_cmd);
                r_key    <= KEY_BITS'(signed'(i_in_key));
                r_hdl    <= i_in_hdl;
                r_status <= ST_OK;
                r_okey   <= '0;
                r_ohdl   <= i_in_hdl;
            end
            DP_REJECT: begin
                r_status <= i_cmd.status;
                if (i_cmd.status == ST_EMPTY) begin
                    r_ohdl <= '0;
                end
            end
            DP_PUSH: begin
                r_pos      <= PW'(r_count);
                r_mv_key   <= r_key;
                r_mv_hdl   <= r_hdl;
                r_try_down <= 1'b0;
            end
            DP_CHANGE: begin
                r_pos      <= r_hpos;
                r_mv_key   <= r_key;
                r_mv_hdl   <= r_hdl;
                r_try_down <= 1'b1;
            end
            DP_RD_ROOT: r_pos <= '0;
            DP_RD_POS:  r_pos <= r_hpos;
            DP_TAKE: begin
                r_okey <= r_rd_key;
                r_ohdl <= r_rd_hdl;
            end
            DP_MV_LAST: begin
                r_mv_key   <= r_rd_key;
                r_mv_hdl   <= r_rd_hdl;
                r_try_down <= 1'b1;
            end
            DP_UP_MOVE: begin
                r_pos      <= parent;
                r_try_down <= 1'b0;
            end
            DP_RD_RIGHT: begin
                r_lft_key <= r_rd_key;
                r_lft_hdl <= r_rd_hdl;
            end
            DP_DOWN_MOVE: r_pos <= c_idx;
            default: r_pos <= r_pos;
        endcase
        if (i_cmd.result) begin
            r_m_user <= r_status;
            r_m_data <= {4'b0, is_empty, CNT_OUT_W'(r_count), min_hdl,
                         IO_KEY_W'(min_key), r_ohdl, IO_KEY_W'(r_okey)};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_live_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_live) == int'(r_count))
        else $error("live handles disagree with entry count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_PUSH) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not add one entry");

endmodule

>>> design/ah_ctrl.sv
// heap sequencer: decodes a command and walks the sift loops
module ah_ctrl
    import ah_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  t_dp_sts i_sts,
    output logic    o_s_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_DECODE  = 13'b0000000000010,
        S_TAKE    = 13'b0000000000100,
        S_LASTCHK = 13'b0000000001000,
        S_MVLAST  = 13'b0000000010000,
        S_UPCHK   = 13'b0000000100000,
        S_UPCMP   = 13'b0000001000000,
        S_DNCHK   = 13'b0000010000000,
        S_DNRDR   = 13'b0000100000000,
        S_DNCMP   = 13'b0001000000000,
        S_PLACE   = 13'b0010000000000,
        S_FINISH  = 13'b0100000000000,
        S_RESULT  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = DP_NOP;
        o_cmd.status  = ST_OK;
        o_cmd.result  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                unique case (i_sts.cmd)
                    CMD_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.op     = DP_REJECT;
                            o_cmd.status = ST_FULL;
                        end else if (i_sts.live) begin
                            o_cmd.op     = DP_REJECT;
                            o_cmd.status = ST_IN_USE;
                        end else begin
                            o_cmd.op = DP_PUSH;
                            n_state  = S_UPCHK;
                        end
                    end
                    CMD_EXTRACT: begin
                        if (i_sts.empty) begin
                            o_cmd.op     = DP_REJECT;
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.op = DP_RD_ROOT;
                            n_state  = S_TAKE;
                        end
                    end
                    CMD_CHANGE: begin
                        if (!i_sts.live) begin
                            o_cmd.op     = DP_REJECT;
                            o_cmd.status = ST_NOT_PRESENT;
                        end else begin
                            o_cmd.op = DP_CHANGE;
                            n_state  = S_UPCHK;
                        end
                    end
                    default: begin
                        if (!i_sts.live) begin
                            o_cmd.op     = DP_REJECT;
                            o_cmd.status = ST_NOT_PRESENT;
                        end else begin
                            o_cmd.op = DP_RD_POS;
                            n_state  = S_TAKE;
                        end
                    end
                endcase
            end
            S_TAKE: begin
                o_cmd.op = DP_TAKE;
                n_state  = S_LASTCHK;
            end
            S_LASTCHK: begin
                // removing the last slot needs no refill
                if (i_sts.at_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = DP_RD_LAST;
                    n_state  = S_MVLAST;
                end
            end
            S_MVLAST: begin
                o_cmd.op = DP_MV_LAST;
                n_state  = S_UPCHK;
            end
            S_UPCHK: begin
                if (!i_sts.pos_zero) begin
                    o_cmd.op = DP_RD_PARENT;
                    n_state  = S_UPCMP;
                end else if (i_sts.try_down) begin
                    n_state = S_DNCHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_UPCMP: begin
                if (i_sts.up_less) begin
                    o_cmd.op = DP_UP_MOVE;
                    n_state  = S_UPCHK;
                end else if (i_sts.try_down) begin
                    n_state = S_DNCHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DNCHK: begin
                if (i_sts.has_left) begin
                    o_cmd.op = DP_RD_LEFT;
                    n_state  = S_DNRDR;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DNRDR: begin
                o_cmd.op = DP_RD_RIGHT;
                n_state  = S_DNCMP;
            end
            S_DNCMP: begin
                if (i_sts.dn_less) begin
                    o_cmd.op = DP_DOWN_MOVE;
                    n_state  = S_DNCHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.op = DP_PLACE;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                // root read feeds the minimum fields
                o_cmd.op = DP_RD_ROOT;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_result_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |=> (r_state == S_IDLE))
        else $error("result issued outside the result step");

    a_place_then_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_PLACE) |=> (r_state == S_FINISH))
        else $error("placement not followed by finish");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_LOAD) |-> (i_s_tvalid && r_state == S_IDLE))
        else $error("command loaded while busy");

endmodule

>>> design/addressable_min_heap.sv
// top level of the addressable binary min-heap
// Usage:
//  slave channel: one beat is one command. tuser carries cmd (push, extract
//  minimum, change key, erase by handle); tdata carries key and handle.
//  master channel: one beat per command. tuser carries status; tdata carries
//  the removed key and handle, the new minimum key and handle, the entry
//  count and the empty flag.
//  Commands run one at a time. The slot memory has a single read port, read
//  once per parent and twice per pair of children.
//  s_tready is high only while no command is in flight.
//  The result sits in an output register; if the receiver stalls, the next
//  command is already accepted and runs, and only its result waits.
//  Reset clears the entry count, the live handle bits and the output valid;
//  slot and handle map memories need no clearing.
module addressable_min_heap
    import ah_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // key[31:0], handle[37:32], zero pad
    input  logic [CMD_W-1:0]    i_s_tuser,  // cmd[1:0]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // out_key[31:0], out_handle[37:32],
                                            // min_key[69:38], min_handle[75:70],
                                            // entry_count[82:76], is_empty[83], pad
    output logic [STS_W-1:0]    o_m_tuser   // status[2:0]
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ah_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (dp_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (dp_cmd)
    );

    ah_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_cmd   (i_s_tuser),
        .i_in_key   (i_s_tdata[IO_KEY_W-1:0]),
        .i_in_hdl   (i_s_tdata[IO_KEY_W+HDL_W-1:IO_KEY_W]),
        .i_m_tready (i_m_tready),
        .o_sts      (dp_sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
